>>> rtl/core/bfbm_pkg.sv
package bfbm_pkg;

  localparam int unsigned PROG_DEPTH = 1024;
  localparam int unsigned TAPE_DEPTH = 32768;
  localparam int unsigned NEST_DEPTH = 256;
  localparam int unsigned MAX_RUN    = 64;

  localparam int unsigned PC_W   = $clog2(PROG_DEPTH);
  localparam int unsigned LEN_W  = $clog2(PROG_DEPTH + 1);
  localparam int unsigned CNT_W  = $clog2(MAX_RUN + 1);
  localparam int unsigned VAL_W  = (PC_W > CNT_W) ? PC_W : CNT_W;
  localparam int unsigned HEAD_W = $clog2(TAPE_DEPTH);
  localparam int unsigned NEST_W = $clog2(NEST_DEPTH);
  localparam int unsigned SP_W   = $clog2(NEST_DEPTH + 1);

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_FINISH = 2'd1;
  localparam logic [1:0] CMD_STEP   = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BYTE     = 3'd1;
  localparam logic [2:0] ST_HALT     = 3'd2;
  localparam logic [2:0] ST_BRACKET  = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_LEFT  = 3'd2,
    OP_RIGHT = 3'd3,
    OP_OPEN  = 3'd4,
    OP_CLOSE = 3'd5,
    OP_READ  = 3'd6,
    OP_WRITE = 3'd7
  } op_e;

  typedef struct packed {
    logic valid;
    op_e  op;
  } cls_t;

  typedef struct packed {
    op_e              op;
    logic [VAL_W-1:0] val;
  } instr_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] char_in;
    logic [7:0] in_byte;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] data_byte;
    logic       input_used;
    logic       last;
  } res_t;

  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [HEAD_W-1:0] addr;
    logic [7:0]        wdata;
  } tape_req_t;

  function automatic cls_t classify(input logic [7:0] ch);
    cls_t c;
    c.valid = 1'b1;
    c.op    = OP_ADD;
    case (ch)
      8'h2B: c.op = OP_ADD;    // +
      8'h2D: c.op = OP_SUB;    // -
      8'h3C: c.op = OP_LEFT;   // <
      8'h3E: c.op = OP_RIGHT;  // >
      8'h5B: c.op = OP_OPEN;   // [
      8'h5D: c.op = OP_CLOSE;  // ]
      8'h2C: c.op = OP_READ;   // ,
      8'h2E: c.op = OP_WRITE;  // .
      default: c.valid = 1'b0;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/core/bfbm_req_if.sv
interface bfbm_req_if import bfbm_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] char_in;
  logic [7:0] in_byte;

  modport source (output valid, command, char_in, in_byte, input ready);
  modport sink (input valid, command, char_in, in_byte, output ready);
endinterface

>>> rtl/core/bfbm_res_if.sv
interface bfbm_res_if import bfbm_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] data_byte;
  logic       input_used;
  logic       last;

  modport source (output valid, status, data_byte, input_used, last, input ready);
  modport sink (input valid, status, data_byte, input_used, last, output ready);
endinterface

>>> rtl/core/bfbm_tape.sv
module bfbm_tape import bfbm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  tape_req_t tape_req_i,
  output logic [7:0] rdata_o,
  output logic      busy_o
);

  logic [7:0]        mem [TAPE_DEPTH];
  logic [HEAD_W:0]   clr_q, clr_d;
  logic              we;
  logic [HEAD_W-1:0] waddr;
  logic [7:0]        wdata;
  logic [7:0]        rdata_q;

  // sweep every cell to zero after reset
  assign busy_o = ~clr_q[HEAD_W];
  assign clr_d  = busy_o ? clr_q + 1'b1 : clr_q;
  assign we     = busy_o | tape_req_i.wr;
  assign waddr  = busy_o ? clr_q[HEAD_W-1:0] : tape_req_i.addr;
  assign wdata  = busy_o ? 8'h00 : tape_req_i.wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (tape_req_i.rd) begin
      rdata_q <= mem[tape_req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/bfbm_ctrl.sv
module bfbm_ctrl import bfbm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  req_t       req_i,
  input  logic       tape_busy_i,
  output tape_req_t  tape_req_o,
  input  logic [7:0] tape_rdata_i,
  output logic       res_valid_o,
  output res_t       res_o,
  input  logic       res_ready_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLOSE1 = 3'd1;
  localparam logic [2:0] S_CLOSE2 = 3'd2;
  localparam logic [2:0] S_EXEC   = 3'd3;
  localparam logic [2:0] S_PRINT  = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [LEN_W-1:0]  pc_q, pc_d;
  logic [SP_W-1:0]   sp_q, sp_d;
  logic [HEAD_W-1:0] head_q, head_d;
  logic              ok_q, ok_d;
  logic [2:0]        fault_q, fault_d;
  op_e               last_op_q, last_op_d;
  logic [VAL_W-1:0]  last_val_q, last_val_d;
  res_t              res_q, res_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [7:0]        cell_q, cell_d;
  logic [7:0]        byte_q, byte_d;

  instr_t            prog_mem [PROG_DEPTH];
  instr_t            prog_rdata_q;
  logic              prog_we, prog_re;
  logic [PC_W-1:0]   prog_waddr;
  instr_t            prog_wdata;

  logic [PC_W-1:0]   stack_mem [NEST_DEPTH];
  logic [PC_W-1:0]   stack_rdata_q;
  logic              stack_we, stack_re;
  logic [NEST_W-1:0] stack_addr;
  logic [PC_W-1:0]   stack_wdata;

  logic              accept;
  cls_t              cls;
  logic [LEN_W-1:0]  eff_len;
  logic [SP_W-1:0]   eff_sp;
  logic [2:0]        eff_fault;
  logic [2:0]        fin_st;
  logic [7:0]        cur_byte;
  instr_t            ins;

  assign req_ready_o = (state_q == S_IDLE) && !tape_busy_i;
  assign accept      = req_valid_i && req_ready_o;
  assign cls         = classify(req_i.char_in);

  // a load after an accepted program sees an empty store
  assign eff_len   = ok_q ? '0 : len_q;
  assign eff_sp    = ok_q ? '0 : sp_q;
  assign eff_fault = ok_q ? ST_OK : fault_q;
  assign fin_st    = (fault_q != ST_OK) ? fault_q :
                     ((sp_q != '0) ? ST_BRACKET : ST_OK);
  assign cur_byte  = tape_rdata_i;
  assign ins       = prog_rdata_q;

  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    pc_d       = pc_q;
    sp_d       = sp_q;
    head_d     = head_q;
    ok_d       = ok_q;
    fault_d    = fault_q;
    last_op_d  = last_op_q;
    last_val_d = last_val_q;
    res_d      = res_q;
    cnt_d      = cnt_q;
    cell_d     = cell_q;
    byte_d     = byte_q;
    prog_we    = 1'b0;
    prog_re    = 1'b0;
    prog_waddr = eff_len[PC_W-1:0];
    prog_wdata = '{op: OP_ADD, val: '0};
    stack_we   = 1'b0;
    stack_re   = 1'b0;
    stack_addr = eff_sp[NEST_W-1:0];
    stack_wdata = eff_len[PC_W-1:0];
    tape_req_o = '{rd: 1'b0, wr: 1'b0, addr: head_q, wdata: '0};
    res_valid_o = 1'b0;
    res_o       = res_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d   = '{status: ST_OK, data_byte: '0, input_used: 1'b0, last: 1'b1};
          state_d = S_RESP;
          byte_d  = req_i.in_byte;
          case (req_i.command)
            CMD_LOAD: begin
              if (ok_q) begin
                ok_d    = 1'b0;
                len_d   = '0;
                pc_d    = '0;
                sp_d    = '0;
                fault_d = ST_OK;
              end
              if (!cls.valid) begin
                res_d.status = ST_OK;
              end else if (eff_fault != ST_OK) begin
                res_d.status = eff_fault;
              end else if (cls.op == OP_CLOSE) begin
                if (eff_sp == '0) begin
                  fault_d      = ST_BRACKET;
                  res_d.status = ST_BRACKET;
                end else if (eff_len >= LEN_W'(PROG_DEPTH)) begin
                  fault_d      = ST_OVERFLOW;
                  res_d.status = ST_OVERFLOW;
                end else begin
                  // pop the partner, then patch it and append the close
                  sp_d       = eff_sp - 1'b1;
                  stack_re   = 1'b1;
                  stack_addr = sp_d[NEST_W-1:0];
                  state_d    = S_CLOSE1;
                end
              end else if (cls.op == OP_OPEN) begin
                if (eff_len >= LEN_W'(PROG_DEPTH) || eff_sp >= SP_W'(NEST_DEPTH)) begin
                  fault_d      = ST_OVERFLOW;
                  res_d.status = ST_OVERFLOW;
                end else begin
                  stack_we   = 1'b1;
                  prog_we    = 1'b1;
                  prog_wdata = '{op: OP_OPEN, val: '0};
                  len_d      = eff_len + 1'b1;
                  sp_d       = eff_sp + 1'b1;
                  last_op_d  = OP_OPEN;
                end
              end else if (cls.op != OP_READ && eff_len != '0 &&
                           last_op_q == cls.op && last_val_q < VAL_W'(MAX_RUN)) begin
                // extend the run held in the newest entry
                prog_we    = 1'b1;
                prog_waddr = PC_W'(eff_len - 1'b1);
                prog_wdata = '{op: cls.op, val: last_val_q + 1'b1};
                last_val_d = last_val_q + 1'b1;
              end else if (eff_len >= LEN_W'(PROG_DEPTH)) begin
                fault_d      = ST_OVERFLOW;
                res_d.status = ST_OVERFLOW;
              end else begin
                prog_we    = 1'b1;
                prog_wdata = '{op: cls.op, val: VAL_W'(1)};
                len_d      = eff_len + 1'b1;
                last_op_d  = cls.op;
                last_val_d = VAL_W'(1);
              end
            end
            CMD_FINISH: begin
              res_d.status = fin_st;
              if (fin_st != ST_OK) begin
                ok_d    = 1'b0;
                len_d   = '0;
                pc_d    = '0;
                sp_d    = '0;
                fault_d = ST_OK;
              end else begin
                ok_d = 1'b1;
                pc_d = '0;
              end
            end
            CMD_STEP: begin
              if (!ok_q || pc_q >= len_q) begin
                res_d.status = ST_HALT;
              end else begin
                // fetch the instruction and the current cell together
                prog_re       = 1'b1;
                tape_req_o.rd = 1'b1;
                state_d       = S_EXEC;
              end
            end
            default: begin
              res_d.status = ST_OK;
            end
          endcase
        end
      end
      S_CLOSE1: begin
        prog_we    = 1'b1;
        prog_waddr = stack_rdata_q;
        prog_wdata = '{op: OP_OPEN, val: VAL_W'(len_q[PC_W-1:0])};
        state_d    = S_CLOSE2;
      end
      S_CLOSE2: begin
        prog_we    = 1'b1;
        prog_waddr = len_q[PC_W-1:0];
        prog_wdata = '{op: OP_CLOSE, val: VAL_W'(stack_rdata_q)};
        len_d      = len_q + 1'b1;
        last_op_d  = OP_CLOSE;
        state_d    = S_RESP;
      end
      S_EXEC: begin
        state_d = S_RESP;
        pc_d    = pc_q + 1'b1;
        case (ins.op)
          OP_ADD: begin
            tape_req_o.wr    = 1'b1;
            tape_req_o.wdata = cur_byte + ins.val[7:0];
          end
          OP_SUB: begin
            tape_req_o.wr    = 1'b1;
            tape_req_o.wdata = cur_byte - ins.val[7:0];
          end
          OP_LEFT:  head_d = head_q - HEAD_W'(ins.val);
          OP_RIGHT: head_d = head_q + HEAD_W'(ins.val);
          OP_OPEN: begin
            if (cur_byte == 8'h00) begin
              pc_d = LEN_W'(ins.val) + 1'b1;
            end
          end
          OP_CLOSE: pc_d = LEN_W'(ins.val);
          OP_READ: begin
            tape_req_o.wr    = 1'b1;
            tape_req_o.wdata = byte_q;
            res_d.input_used = 1'b1;
          end
          default: begin
            // print: clamp the count to one through the run limit
            cell_d  = cur_byte;
            state_d = S_PRINT;
            if (ins.val == '0) begin
              cnt_d = CNT_W'(1);
            end else if (ins.val > VAL_W'(MAX_RUN)) begin
              cnt_d = CNT_W'(MAX_RUN);
            end else begin
              cnt_d = CNT_W'(ins.val);
            end
          end
        endcase
      end
      S_PRINT: begin
        res_valid_o = 1'b1;
        res_o = '{status: ST_BYTE, data_byte: cell_q, input_used: 1'b0,
                  last: (cnt_q == CNT_W'(1))};
        if (res_ready_i) begin
          cnt_d = cnt_q - 1'b1;
          if (cnt_q == CNT_W'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      len_q      <= '0;
      pc_q       <= '0;
      sp_q       <= '0;
      head_q     <= '0;
      ok_q       <= 1'b0;
      fault_q    <= ST_OK;
      last_op_q  <= OP_ADD;
      last_val_q <= '0;
      cnt_q      <= '0;
    end else begin
      state_q    <= state_d;
      len_q      <= len_d;
      pc_q       <= pc_d;
      sp_q       <= sp_d;
      head_q     <= head_d;
      ok_q       <= ok_d;
      fault_q    <= fault_d;
      last_op_q  <= last_op_d;
      last_val_q <= last_val_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    cell_q <= cell_d;
    byte_q <= byte_d;
  end

  always_ff @(posedge clk_i) begin
    if (prog_we) begin
      prog_mem[prog_waddr] <= prog_wdata;
    end
    if (prog_re) begin
      prog_rdata_q <= prog_mem[pc_q[PC_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[stack_addr] <= stack_wdata;
    end
    if (stack_re) begin
      stack_rdata_q <= stack_mem[stack_addr];
    end
  end

endmodule

>>> rtl/core/bf_bytecode_machine_core.sv
// A load goes from idle to the response state, via CLOSE1 and CLOSE2 for a closing bracket;
// a finish goes straight there; a step reads program and tape memories together, then writes
// back in EXEC. A new request is taken only in idle; a print emits one byte per cycle while
// the output is not stalled. Reset: asynchronous, active low; clears all control state, then
// sweeps all 32768 tape cells to zero, during which no request is accepted.
module bf_bytecode_machine_core import bfbm_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  bfbm_req_if.sink   req_i,
  bfbm_res_if.source res_o
);

  req_t       req;
  logic       ctrl_ready;
  tape_req_t  tape_req;
  logic [7:0] tape_rdata;
  logic       tape_busy;
  logic       res_valid;
  res_t       res;
  logic       res_ready;

  logic       out_valid_q, out_valid_d;
  res_t       out_q;

  // pack the request payload for the controller
  assign req = '{command: req_i.command, char_in: req_i.char_in, in_byte: req_i.in_byte};
  assign req_i.ready = ctrl_ready;

  bfbm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_ready_o  (ctrl_ready),
    .req_i        (req),
    .tape_busy_i  (tape_busy),
    .tape_req_o   (tape_req),
    .tape_rdata_i (tape_rdata),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (res_ready)
  );

  bfbm_tape u_tape (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tape_req_i (tape_req),
    .rdata_o    (tape_rdata),
    .busy_o     (tape_busy)
  );

  // Output register: take a new result whenever the slot is empty or
  // being drained this cycle, so the controller never waits on an idle sink.
  assign res_ready = !out_valid_q || res_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.status     = out_q.status;
  assign res_o.data_byte  = out_q.data_byte;
  assign res_o.input_used = out_q.input_used;
  assign res_o.last       = out_q.last;

  // No request slips in while the tape is still being cleared.
  a_no_req_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |-> !tape_busy)
    else $error("request accepted during tape clear");

  // Controller writes never collide with the clearing sweep.
  a_no_write_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tape_req.wr |-> !tape_busy)
    else $error("tape write during clear");

  // Only a print spreads over several results.
  a_single_result_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status != ST_BYTE |-> out_q.last)
    else $error("non-print result without last");

  // A consumed input byte comes only with an ok step.
  a_input_used_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.input_used |-> out_q.status == ST_OK)
    else $error("input_used on a non-ok result");

endmodule
